// ----- hw/rtl/tces_pkg.sv -----
// ----------------------------------------------------------------------------
// tces_pkg
// shared constants and widths for the toy processor execute step
// ----------------------------------------------------------------------------
package tces_pkg;

  // default depth of the return-address stack
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned PC_W   = 16;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned RIDX_W = 2;
  localparam int unsigned OP_W   = 8;
  localparam int unsigned IMM_W  = 16;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_PROG_LEN = 1'b0;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD = 8'h01;
  localparam logic [OP_W-1:0] OP_ADD  = 8'h02;
  localparam logic [OP_W-1:0] OP_CALL = 8'h03;
  localparam logic [OP_W-1:0] OP_RET  = 8'h04;
  localparam logic [OP_W-1:0] OP_HLT  = 8'hFF;

  // highest legal register index in an instruction
  localparam logic [OP_W-1:0] REG_IDX_MAX = 8'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_REG  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_OP   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

endpackage

// ----- hw/rtl/tces_instr_if.sv -----
// ----------------------------------------------------------------------------
// tces_instr_if
// instruction request channel: one 32-bit instruction word per request
// ----------------------------------------------------------------------------
interface tces_instr_if
  import tces_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

// ----- hw/rtl/tces_result_if.sv -----
// ----------------------------------------------------------------------------
// tces_result_if
// result request channel: new counter, run flag, error and register write
// ----------------------------------------------------------------------------
interface tces_result_if
  import tces_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_pc;
  logic                     running;
  logic [ERR_W-1:0]         error_code;
  logic                     write_valid;
  logic [RIDX_W-1:0]        write_index;
  logic signed [WORD_W-1:0] write_value;

  modport source (
    output valid, output next_pc, output running, output error_code,
    output write_valid, output write_index, output write_value, input ready
  );
  modport sink (
    input valid, input next_pc, input running, input error_code,
    input write_valid, input write_index, input write_value, output ready
  );
endinterface

// ----- hw/rtl/toy_cpu_execute_step_top.sv -----
// ----------------------------------------------------------------------------
// toy_cpu_execute_step_top
// toy processor executing one instruction word per request
// ----------------------------------------------------------------------------
// The block takes one instruction per clock cycle unless the output stalls,
// and returns one result per instruction. The register file (four words, two
// read ports) and the return-address stack are synchronous memories read at
// the edge that accepts the request; the instruction executes from the
// execute stage register and its result lands in an output register, so a
// new request is taken while a finished result still waits downstream. A
// write to the register file or a push made by one instruction is forwarded
// to the instruction right behind it. No clearing pass is needed after reset.
// The user must write the program length register over the APB port only
// while the block is idle, which it does not enforce; pready is always high.
module toy_cpu_execute_step_top
  import tces_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tces_instr_if.sink            instr_i,
  tces_result_if.source         result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // configuration register
  logic [PC_W-1:0] prog_len_q;

  // architectural scalars
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             halted_q, halted_d;

  // memories
  logic [WORD_W-1:0] rf_mem  [4];
  logic [PC_W-1:0]   stk_mem [STACK_DEPTH];
  logic [3:0]        rf_vld_q;

  // execute stage
  logic              e_vld_q;
  logic [WORD_W-1:0] e_word_q;
  logic [WORD_W-1:0] rd_a_q, rd_b_q;
  logic              rd_a_vld_q, rd_b_vld_q;
  logic [PC_W-1:0]   stk_rd_q;

  // forwarding of the write made at the read edge
  logic              fwd_rf_q;
  logic [RIDX_W-1:0] fwd_idx_q;
  logic [WORD_W-1:0] fwd_val_q;
  logic              fwd_stk_q;
  logic [PC_W-1:0]   fwd_top_q;

  // output register
  logic                     out_vld_q;
  logic [PC_W-1:0]          out_pc_q;
  logic                     out_run_q;
  logic [ERR_W-1:0]         out_err_q;
  logic                     out_wv_q;
  logic [RIDX_W-1:0]        out_wi_q;
  logic [WORD_W-1:0]        out_wval_q;

  // execute signals
  logic              in_fire, e_adv;
  logic [OP_W-1:0]   op_e, ra_e, rb_e;
  logic [IMM_W-1:0]  imm_e;
  logic              active;
  logic [PC_W-1:0]   pc_inc;
  logic [WORD_W-1:0] opnd_a, opnd_b;
  logic [PC_W-1:0]   stk_top;
  logic [ERR_W-1:0]  err;
  logic              wr_en, push_en;
  logic [RIDX_W-1:0] wr_idx;
  logic [WORD_W-1:0] wr_val;
  logic              run_d;
  logic [SAW-1:0]    stk_raddr;
  logic [CNT_W-1:0]  cnt_dec;
  logic [RIDX_W-1:0] ra_in, rb_in;

  // handshakes
  assign e_adv   = e_vld_q && (!out_vld_q || result_o.ready);
  assign instr_i.ready = !e_vld_q || e_adv;
  assign in_fire = instr_i.valid && instr_i.ready;

  // apb port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PROG_LEN) begin
      prdata = {{(APB_DATA_W-PC_W){1'b0}}, prog_len_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PROG_LEN) begin
      prog_len_q <= pwdata[PC_W-1:0];
    end
  end

  // instruction fields in execute
  assign op_e  = e_word_q[31:24];
  assign ra_e  = e_word_q[23:16];
  assign rb_e  = e_word_q[15:8];
  assign imm_e = e_word_q[15:0];
  assign ra_in = instr_i.instr_word[17:16];
  assign rb_in = instr_i.instr_word[9:8];

  // operands with forwarding; unwritten registers read as zero
  always_comb begin
    opnd_a = rd_a_vld_q ? rd_a_q : '0;
    opnd_b = rd_b_vld_q ? rd_b_q : '0;
    if (fwd_rf_q && fwd_idx_q == ra_e[RIDX_W-1:0]) begin
      opnd_a = fwd_val_q;
    end
    if (fwd_rf_q && fwd_idx_q == rb_e[RIDX_W-1:0]) begin
      opnd_b = fwd_val_q;
    end
  end

  assign stk_top = fwd_stk_q ? fwd_top_q : stk_rd_q;
  assign active  = !halted_q && (pc_q < prog_len_q);
  assign pc_inc  = pc_q + PC_W'(1);

  // execute
  always_comb begin
    pc_d     = pc_q;
    cnt_d    = cnt_q;
    halted_d = halted_q;
    err      = ERR_NONE;
    wr_en    = 1'b0;
    wr_idx   = '0;
    wr_val   = '0;
    push_en  = 1'b0;
    if (e_adv && active) begin
      pc_d = pc_inc;
      case (op_e)
        OP_LOAD: begin
          if (ra_e > REG_IDX_MAX) begin
            err      = ERR_BAD_REG;
            halted_d = 1'b1;
          end else begin
            wr_en  = 1'b1;
            wr_idx = ra_e[RIDX_W-1:0];
            wr_val = {{(WORD_W-IMM_W){1'b0}}, imm_e};
          end
        end
        OP_ADD: begin
          if (ra_e > REG_IDX_MAX || rb_e > REG_IDX_MAX) begin
            err      = ERR_BAD_REG;
            halted_d = 1'b1;
          end else begin
            wr_en  = 1'b1;
            wr_idx = '0;
            wr_val = opnd_a + opnd_b;
          end
        end
        OP_CALL: begin
          if (cnt_q == CNT_W'(STACK_DEPTH)) begin
            err      = ERR_OVERFLOW;
            halted_d = 1'b1;
          end else begin
            push_en = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
            pc_d    = imm_e - PC_W'(1);
          end
        end
        OP_RET: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CNT_W'(1);
            pc_d  = stk_top;
          end
        end
        OP_HLT: begin
          halted_d = 1'b1;
        end
        default: begin
          err = ERR_BAD_OP;
        end
      endcase
    end
  end

  assign run_d     = !halted_d && (pc_d < prog_len_q);
  assign cnt_dec   = cnt_d - CNT_W'(1);
  assign stk_raddr = cnt_dec[SAW-1:0];

  // architectural state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      cnt_q     <= '0;
      halted_q  <= 1'b0;
      rf_vld_q  <= '0;
      e_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_rf_q  <= 1'b0;
      fwd_stk_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
      if (wr_en) begin
        rf_vld_q[wr_idx] <= 1'b1;
      end
      if (in_fire) begin
        e_vld_q   <= 1'b1;
        fwd_rf_q  <= wr_en;
        fwd_stk_q <= push_en;
      end else if (e_adv) begin
        e_vld_q <= 1'b0;
      end
      if (e_adv) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rf_mem[wr_idx] <= wr_val;
    end
    if (in_fire) begin
      rd_a_q     <= rf_mem[ra_in];
      rd_b_q     <= rf_mem[rb_in];
      rd_a_vld_q <= rf_vld_q[ra_in];
      rd_b_vld_q <= rf_vld_q[rb_in];
    end
  end

  // return stack: push at the count, read the top after this update
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stk_mem[cnt_q[SAW-1:0]] <= pc_inc;
    end
    if (in_fire) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  // execute stage payload and forwarding data
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_word_q  <= instr_i.instr_word;
      fwd_idx_q <= wr_idx;
      fwd_val_q <= wr_val;
      fwd_top_q <= pc_inc;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (e_adv) begin
      out_pc_q   <= pc_d;
      out_run_q  <= run_d;
      out_err_q  <= err;
      out_wv_q   <= wr_en;
      out_wi_q   <= wr_idx;
      out_wval_q <= wr_val;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.next_pc     = out_pc_q;
  assign result_o.running     = out_run_q;
  assign result_o.error_code  = out_err_q;
  assign result_o.write_valid = out_wv_q;
  assign result_o.write_index = out_wi_q;
  assign result_o.write_value = out_wval_q;

endmodule

// ----- sim/toy_cpu_execute_step_top_tb.sv -----
// ----------------------------------------------------------------------------
// toy_cpu_execute_step_top_tb
// self-checking bench for the toy processor execute step
// ----------------------------------------------------------------------------
// Instruction words are pushed through the request channel in random bursts
// while the result side stalls on its own pattern. A local model of the
// processor state predicts every result, which is checked field by field in
// order. Directed cases run first, then balanced call/return programs with
// random arithmetic over a range of program lengths, then one stopping case.
// The program length is set over APB between phases and read back.
module toy_cpu_execute_step_top_tb
  import tces_pkg::*;
();

  localparam int unsigned STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int          RAND_ITEMS  = 1400;
  localparam int          PHASE_ITEMS = 250;
  localparam int          CYCLE_LIMIT = 300000;
  localparam logic [APB_ADDR_W-1:0] ADDR_PROG_LEN = {REG_PROG_LEN, 2'b00};

  // one expected result
  typedef struct {
    logic [PC_W-1:0]          next_pc;
    logic                     running;
    logic [ERR_W-1:0]         error_code;
    logic                     write_valid;
    logic [RIDX_W-1:0]        write_index;
    logic signed [WORD_W-1:0] write_value;
  } step_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tces_instr_if  instr_ch ();
  tces_result_if result_ch ();

  toy_cpu_execute_step_top #(
    .STACK_DEPTH (STACK_DEPTH)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .instr_i  (instr_ch),
    .result_o (result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // processor state as predicted
  logic [PC_W-1:0]   cur_pc;
  logic [WORD_W-1:0] gpr [4];
  logic [PC_W-1:0]   ret_stack [STACK_DEPTH];
  int                stack_cnt;
  logic              cpu_halted;
  logic [PC_W-1:0]   prog_len;

  step_res_t pending_results [$];

  // run statistics
  int fail_cnt;
  int in_cnt;
  int exec_cnt;
  int checked_cnt;
  int cfg_cnt;
  int max_depth;
  int err_seen [4];
  string stop_kind;

  // sender and receiver control
  int   burst_left;
  bit   no_gaps;
  int   hold_req;
  int   hold_left;
  int   sink_mode;
  int   mode_left;
  logic [7:0] stall_pat;
  int   cycle_cnt;

  // execute one instruction on the predicted state
  function automatic step_res_t exec_instr(input logic [WORD_W-1:0] w);
    step_res_t         r;
    logic [OP_W-1:0]   op;
    logic [7:0]        ra;
    logic [7:0]        rb;
    logic [IMM_W-1:0]  imm;
    logic [WORD_W-1:0] sum;
    op  = w[31:24];
    ra  = w[23:16];
    rb  = w[15:8];
    imm = w[15:0];
    r = '{default: '0};
    if (!cpu_halted && cur_pc < prog_len) begin
      exec_cnt++;
      cur_pc = cur_pc + 1'b1;
      case (op)
        OP_LOAD: begin
          if (ra > REG_IDX_MAX) begin
            r.error_code = ERR_BAD_REG;
            cpu_halted = 1'b1;
          end else begin
            gpr[ra[1:0]] = {16'b0, imm};
            r.write_valid = 1'b1;
            r.write_index = ra[1:0];
            r.write_value = {16'b0, imm};
          end
        end
        OP_ADD: begin
          if (ra > REG_IDX_MAX || rb > REG_IDX_MAX) begin
            r.error_code = ERR_BAD_REG;
            cpu_halted = 1'b1;
          end else begin
            sum = gpr[ra[1:0]] + gpr[rb[1:0]];
            gpr[0] = sum;
            r.write_valid = 1'b1;
            r.write_index = '0;
            r.write_value = sum;
          end
        end
        OP_CALL: begin
          if (stack_cnt >= STACK_DEPTH) begin
            r.error_code = ERR_OVERFLOW;
            cpu_halted = 1'b1;
          end else begin
            ret_stack[stack_cnt] = cur_pc;
            stack_cnt++;
            if (stack_cnt > max_depth) max_depth = stack_cnt;
            cur_pc = imm - 1'b1;
          end
        end
        OP_RET: begin
          if (stack_cnt > 0) begin
            stack_cnt--;
            cur_pc = ret_stack[stack_cnt];
          end
        end
        OP_HLT: begin
          cpu_halted = 1'b1;
        end
        default: begin
          r.error_code = ERR_BAD_OP;
        end
      endcase
      err_seen[r.error_code]++;
    end
    r.next_pc = cur_pc;
    r.running = !cpu_halted && cur_pc < prog_len;
    return r;
  endfunction

  function automatic bit cpu_stuck();
    return cpu_halted || cur_pc >= prog_len;
  endfunction

  function automatic logic [WORD_W-1:0] encode(input logic [OP_W-1:0] op,
                                               input logic [7:0] ra,
                                               input logic [IMM_W-1:0] low);
    return {op, ra, low};
  endfunction

  // jump target that lands inside the program and well clear of the top
  function automatic logic [IMM_W-1:0] call_target();
    int unsigned top;
    top = (prog_len < 16'hF000) ? prog_len : 16'hF000;
    if (top == 0) top = 1;
    return IMM_W'($urandom_range(1, top));
  endfunction

  // send one instruction request, predicting its result on acceptance
  task automatic push_instr(input logic [WORD_W-1:0] w);
    if (burst_left == 0) begin
      if (!no_gaps && $urandom_range(0, 2) != 0) begin
        instr_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    instr_ch.valid      <= 1'b1;
    instr_ch.instr_word <= w;
    @(posedge clk_i);
    while (!instr_ch.ready) @(posedge clk_i);
    pending_results.push_back(exec_instr(w));
    in_cnt++;
    burst_left--;
  endtask

  // send only while the processor would actually execute
  task automatic issue(input logic [WORD_W-1:0] w);
    if (!cpu_stuck()) push_instr(w);
  endtask

  task automatic wait_results_drained();
    instr_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // program length write over apb, then read back
  task automatic write_prog_len(input logic [PC_W-1:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_PROG_LEN;
    pwdata  <= APB_DATA_W'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== APB_DATA_W'(len)) begin
      $display("%0t: program length readback mismatch, expected %0h, actual %0h",
               $time, APB_DATA_W'(len), prdata);
      fail_cnt++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    prog_len = len;
    cfg_cnt++;
    @(posedge clk_i);
  endtask

  // random load or add on legal registers
  task automatic issue_arith();
    logic [IMM_W-1:0] imm;
    logic [7:0]       ra;
    logic [7:0]       rb;
    ra = 8'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0:       imm = '1;
        1:       imm = '0;
        2:       imm = 16'h8000;
        default: imm = IMM_W'($urandom);
      endcase
      issue(encode(OP_LOAD, ra, imm));
    end else begin
      // bias towards accumulating in r0 so sums grow and wrap
      if ($urandom_range(0, 1) == 0) ra = '0;
      rb = 8'($urandom_range(0, 3));
      issue(encode(OP_ADD, ra, {rb, 8'($urandom)}));
    end
  endtask

  task automatic issue_call();
    issue(encode(OP_CALL, 8'($urandom), call_target()));
  endtask

  // unknown opcodes and stray returns
  task automatic issue_noise();
    logic [OP_W-1:0] op;
    if ($urandom_range(0, 2) == 0) begin
      issue(encode(OP_RET, 8'($urandom), IMM_W'($urandom)));
    end else begin
      op = OP_W'($urandom);
      while (op inside {OP_LOAD, OP_ADD, OP_CALL, OP_RET, OP_HLT}) op = OP_W'($urandom);
      issue(encode(op, 8'($urandom), IMM_W'($urandom)));
    end
  endtask

  // one well-formed fragment of a program, or a little noise
  task automatic run_sequence();
    int kind;
    int room;
    int n;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      repeat ($urandom_range(1, 8)) issue_arith();
    end else if (kind <= 7 && stack_cnt < STACK_DEPTH) begin
      room = STACK_DEPTH - stack_cnt;
      n = ($urandom_range(0, 3) == 0) ? room : $urandom_range(1, room);
      repeat (n) begin
        issue_call();
        repeat ($urandom_range(0, 2)) issue_arith();
      end
      repeat (n) begin
        repeat ($urandom_range(0, 2)) issue_arith();
        issue(encode(OP_RET, 8'($urandom), IMM_W'($urandom)));
      end
    end else if (kind == 8) begin
      if (stack_cnt < STACK_DEPTH && $urandom_range(0, 1) == 0) issue_call();
      else issue(encode(OP_RET, 8'($urandom), IMM_W'($urandom)));
    end else begin
      issue_noise();
    end
  endtask

  // zero length after reset: everything is ignored
  task automatic test_reset_idle();
    write_prog_len('0);
    push_instr(encode(OP_LOAD, 8'd1, 16'h1234));
    push_instr(encode(OP_CALL, 8'd0, 16'h0005));
    push_instr(encode(OP_HLT, 8'hFF, 16'hFFFF));
    wait_results_drained();
  endtask

  // every opcode but halt once or more at full length
  task automatic test_opcodes();
    write_prog_len('1);
    push_instr(encode(OP_LOAD, 8'd0, 16'hFFFF));
    push_instr(encode(OP_LOAD, 8'd1, 16'h0000));
    push_instr(encode(OP_LOAD, 8'd2, 16'h8000));
    push_instr(encode(OP_LOAD, 8'd3, 16'h7FFF));
    // back-to-back adds read the register just written
    push_instr(encode(OP_ADD, 8'd0, {8'd2, 8'h00}));
    push_instr(encode(OP_ADD, 8'd0, {8'd0, 8'hFF}));
    push_instr(encode(OP_ADD, 8'd3, {8'd3, 8'h5A}));
    push_instr(encode(8'h00, 8'h00, 16'h0000));
    push_instr(encode(8'h05, 8'hFF, 16'hFFFF));
    push_instr(encode(8'hFE, 8'h12, 16'h3456));
    // return on an empty stack only advances
    push_instr(encode(OP_RET, 8'd0, 16'h0000));
    // call straight into return uses the fresh push
    push_instr(encode(OP_CALL, 8'd0, 16'h0010));
    push_instr(encode(OP_RET, 8'd0, 16'h0000));
    push_instr(encode(OP_CALL, 8'hFF, 16'hF000));
    push_instr(encode(OP_CALL, 8'h00, 16'h0001));
    push_instr(encode(OP_RET, 8'hAA, 16'hFFFF));
    push_instr(encode(OP_RET, 8'h55, 16'h0000));
  endtask

  // counter running into the program end, then resuming on a longer length
  task automatic test_length_edge();
    push_instr(encode(OP_CALL, 8'd0, 16'h0001));
    wait_results_drained();
    write_prog_len(16'd1);
    push_instr(encode(OP_LOAD, 8'd2, 16'h00AA));
    push_instr(encode(OP_LOAD, 8'd3, 16'h0055));
    wait_results_drained();
    write_prog_len(16'd3);
    push_instr(encode(OP_ADD, 8'd2, {8'd2, 8'h00}));
    push_instr(encode(OP_RET, 8'd0, 16'h0000));
    wait_results_drained();
    write_prog_len('1);
  endtask

  // long hold on the result side while requests keep coming
  task automatic test_backpressure();
    no_gaps  = 1'b1;
    hold_req = 300;
    repeat (40) issue_arith();
    no_gaps = 1'b0;
  endtask

  // random programs over many program lengths
  task automatic test_random_programs();
    int start_cnt;
    int phase_start;
    logic [PC_W-1:0] new_len;
    start_cnt   = exec_cnt;
    phase_start = exec_cnt;
    while (exec_cnt - start_cnt < RAND_ITEMS) begin
      if (cpu_stuck() || exec_cnt - phase_start >= PHASE_ITEMS) begin
        if (cpu_stuck()) repeat ($urandom_range(1, 2)) push_instr($urandom);
        wait_results_drained();
        case ($urandom_range(0, 3))
          0:       new_len = '1;
          1:       new_len = cur_pc + 1'b1;
          2:       new_len = cur_pc + PC_W'($urandom_range(2, 40));
          default: new_len = PC_W'($urandom_range(int'(cur_pc) + 1, 65535));
        endcase
        write_prog_len(new_len);
        phase_start = exec_cnt;
      end
      run_sequence();
    end
  endtask

  // one way of stopping for good, then a few ignored requests
  task automatic test_final_stop();
    wait_results_drained();
    write_prog_len('1);
    case ($urandom_range(0, 3))
      0: begin
        stop_kind = "halt instruction";
        issue(encode(OP_HLT, 8'($urandom), IMM_W'($urandom)));
      end
      1: begin
        stop_kind = "bad register index";
        if ($urandom_range(0, 1) == 0)
          issue(encode(OP_LOAD, 8'($urandom_range(4, 255)), IMM_W'($urandom)));
        else
          issue(encode(OP_ADD, 8'($urandom_range(0, 3)),
                       {8'($urandom_range(4, 255)), 8'($urandom)}));
      end
      2: begin
        stop_kind = "stack overflow";
        while (stack_cnt < STACK_DEPTH && !cpu_stuck()) issue_call();
        issue_call();
      end
      default: begin
        stop_kind = "counter wrap to the top";
        while (stack_cnt >= STACK_DEPTH && !cpu_stuck())
          issue(encode(OP_RET, 8'd0, 16'h0000));
        issue(encode(OP_CALL, 8'($urandom), 16'h0000));
      end
    endcase
    repeat (4) push_instr($urandom);
  endtask

  // result checking and receiver stalls
  task automatic check_field(input string fname, input logic [WORD_W-1:0] want_v,
                             input logic [WORD_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_sink
    step_res_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting, next_pc %0h", $time,
                 result_ch.next_pc);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", WORD_W'(want.next_pc), WORD_W'(result_ch.next_pc));
        check_field("running", WORD_W'(want.running), WORD_W'(result_ch.running));
        check_field("error_code", WORD_W'(want.error_code), WORD_W'(result_ch.error_code));
        check_field("write_valid", WORD_W'(want.write_valid),
                    WORD_W'(result_ch.write_valid));
        check_field("write_index", WORD_W'(want.write_index),
                    WORD_W'(result_ch.write_index));
        check_field("write_value", want.write_value, result_ch.write_value);
        checked_cnt++;
      end
    end
    // long hold first, otherwise a stall pattern that changes now and then
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
        stall_pat = 8'($urandom) | 8'h01;
      end
      mode_left--;
      case (sink_mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= 1'($urandom_range(0, 1));
        default: result_ch.ready <= stall_pat[cycle_cnt % 8];
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_ni              = 1'b0;
    instr_ch.valid      = 1'b0;
    instr_ch.instr_word = '0;
    result_ch.ready     = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cur_pc              = '0;
    gpr                 = '{default: '0};
    stack_cnt           = 0;
    cpu_halted          = 1'b0;
    prog_len            = '0;
    stop_kind           = "none";
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_idle();
    test_opcodes();
    test_length_edge();
    test_backpressure();
    test_random_programs();
    test_final_stop();

    wait_results_drained();
    repeat (8) @(posedge clk_i);

    $display("%0d requests (%0d executed), %0d results checked, %0d length settings",
             in_cnt, exec_cnt, checked_cnt, cfg_cnt);
    $display("deepest stack %0d; bad register %0d, bad opcode %0d, overflow %0d; stop by %s",
             max_depth, err_seen[ERR_BAD_REG], err_seen[ERR_BAD_OP],
             err_seen[ERR_OVERFLOW], stop_kind);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
